FILE: rtl/core/bcpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcpc_pkg
// Shared constants for the bilinear crop/patch compositor.
// ----------------------------------------------------------------------------
package bcpc_pkg;

	localparam int STORE_WIDTH   = 128;
	localparam int STORE_HEIGHT  = 128;
	localparam int CHANNELS      = 3;
	localparam int FRACTION_BITS = 8;
	localparam int COORD_BITS    = 12;

	// crop bounds are 7-bit registers; crop span fits in 8 bits
	localparam int SRC_BITS  = 7;
	localparam int SPAN_BITS = 8;
	localparam int IO_CH     = 3;
	localparam int PIX_BITS  = 8;
	localparam int CFG_IDX_W = 3;
	localparam int POS_W     = 13;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_TOP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_RIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_BOTTOM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DST_LEFT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DST_TOP    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DST_RIGHT  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DST_BOTTOM = 3'd7;

	localparam logic FUNC_LOAD    = 1'b0;
	localparam logic FUNC_PROCESS = 1'b1;

endpackage
`default_nettype wire

FILE: rtl/core/bilinear_crop_patch_compositor_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_crop_patch_compositor_top
// Crops a region of an on-chip source image, scales it bilinearly to a patch
// rectangle and pastes it over a stream of destination pixels.
// ----------------------------------------------------------------------------
// One beat per clock in each direction while out_ready is high; a result
// not taken stalls the whole pipeline. Stages: one multiply stage, one divider
// stage per quotient bit of the two pipelined position dividers
// (FRACTION_BITS+7), address/clamp, store read, weight products, sum. The
// source store is split into four banks by column and row parity so the four
// neighbours of a sample are read in the same cycle. Loads write the store in
// the same stage where samples read it, so a sample always sees every load
// that came before it. The store has no reset and needs no clearing pass;
// samples of unwritten pixels are undefined. Configuration is taken at once
// and must only change while no beat is in flight.
module bilinear_crop_patch_compositor_top #(
	parameter int STORE_WIDTH   = bcpc_pkg::STORE_WIDTH,
	parameter int STORE_HEIGHT  = bcpc_pkg::STORE_HEIGHT,
	parameter int CHANNELS      = bcpc_pkg::CHANNELS,
	parameter int FRACTION_BITS = bcpc_pkg::FRACTION_BITS,
	parameter int COORD_BITS    = bcpc_pkg::COORD_BITS
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [bcpc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [COORD_BITS-1:0]                 cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic                                  func,
	input  wire logic [COORD_BITS-1:0]                 pos_x,
	input  wire logic [COORD_BITS-1:0]                 pos_y,
	input  wire logic [bcpc_pkg::PIX_BITS-1:0]         chan0,
	input  wire logic [bcpc_pkg::PIX_BITS-1:0]         chan1,
	input  wire logic [bcpc_pkg::PIX_BITS-1:0]         chan2,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [bcpc_pkg::PIX_BITS-1:0]              pix0,
	output logic [bcpc_pkg::PIX_BITS-1:0]              pix1,
	output logic [bcpc_pkg::PIX_BITS-1:0]              pix2,
	output logic                                       in_patch
);

	localparam int CB  = COORD_BITS;
	localparam int F   = FRACTION_BITS;
	localparam int SB  = bcpc_pkg::SRC_BITS;
	localparam int LB  = bcpc_pkg::SPAN_BITS;
	localparam int PB  = bcpc_pkg::PIX_BITS;
	localparam int PW  = bcpc_pkg::POS_W;
	localparam int QB  = SB + F;
	localparam int NW  = CB + LB + F;
	localparam int XB  = $clog2(STORE_WIDTH);
	localparam int YB  = $clog2(STORE_HEIGHT);
	localparam int SCH = (CHANNELS < bcpc_pkg::IO_CH) ? CHANNELS : bcpc_pkg::IO_CH;
	localparam int SW  = SCH * PB;
	localparam int HW  = (STORE_WIDTH + 1) / 2;
	localparam int HH  = (STORE_HEIGHT + 1) / 2;
	localparam int BD  = HW * HH;
	localparam int AW  = (BD > 1) ? $clog2(BD) : 1;
	localparam int WW  = 2 * F + 2;
	localparam int MW  = WW + PB;
	localparam int UW  = MW + 2;
	localparam logic [PW-1:0] XLAST = PW'(STORE_WIDTH - 1);
	localparam logic [PW-1:0] YLAST = PW'(STORE_HEIGHT - 1);
	localparam logic [F:0]    ONE   = (F+1)'(1) << F;

	// ---------------- configuration
	logic [SB-1:0] src_left_q, src_top_q, src_right_q, src_bottom_q;
	logic [CB-1:0] dst_left_q, dst_top_q, dst_right_q, dst_bottom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_left_q   <= '0;
			src_top_q    <= '0;
			src_right_q  <= SB'(127);
			src_bottom_q <= SB'(127);
			dst_left_q   <= '0;
			dst_top_q    <= '0;
			dst_right_q  <= CB'(127);
			dst_bottom_q <= CB'(127);
		end else if (cfg_we) begin
			case (cfg_index)
				bcpc_pkg::REG_SRC_LEFT:   src_left_q   <= cfg_data[SB-1:0];
				bcpc_pkg::REG_SRC_TOP:    src_top_q    <= cfg_data[SB-1:0];
				bcpc_pkg::REG_SRC_RIGHT:  src_right_q  <= cfg_data[SB-1:0];
				bcpc_pkg::REG_SRC_BOTTOM: src_bottom_q <= cfg_data[SB-1:0];
				bcpc_pkg::REG_DST_LEFT:   dst_left_q   <= cfg_data;
				bcpc_pkg::REG_DST_TOP:    dst_top_q    <= cfg_data;
				bcpc_pkg::REG_DST_RIGHT:  dst_right_q  <= cfg_data;
				bcpc_pkg::REG_DST_BOTTOM: dst_bottom_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline advances together; the output register frees on a taken beat
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// ---------------- input stage: offsets, spans, numerators
	logic          inside_c;
	logic [CB-1:0] dx_c, dy_c;
	logic [CB:0]   lx_c, ly_c;
	logic [LB-1:0] sx_c, sy_c;
	logic [NW-1:0] nx_c, ny_c;

	always_comb begin
		inside_c = (pos_x >= dst_left_q) && (pos_x <= dst_right_q) &&
			(pos_y >= dst_top_q) && (pos_y <= dst_bottom_q);
		dx_c = pos_x - dst_left_q;
		dy_c = pos_y - dst_top_q;
		lx_c = {1'b0, dst_right_q} - {1'b0, dst_left_q} + (CB+1)'(1);
		ly_c = {1'b0, dst_bottom_q} - {1'b0, dst_top_q} + (CB+1)'(1);
		sx_c = (src_right_q >= src_left_q) ?
			{1'b0, src_right_q - src_left_q} + LB'(1) : LB'(1);
		sy_c = (src_bottom_q >= src_top_q) ?
			{1'b0, src_bottom_q - src_top_q} + LB'(1) : LB'(1);
		nx_c = NW'(dx_c * sx_c) << F;
		ny_c = NW'(dy_c * sy_c) << F;
	end

	// ---------------- divider pipeline, one quotient bit per stage
	logic [QB:0]       dv_v_s2, dv_f_s2, dv_in_s2;
	logic [CB-1:0]     dv_x_s2  [QB+1];
	logic [CB-1:0]     dv_y_s2  [QB+1];
	logic [3*PB-1:0]   dv_ch_s2 [QB+1];
	logic [CB:0]       dv_lx_s2 [QB+1];
	logic [CB:0]       dv_ly_s2 [QB+1];
	logic [CB:0]       dv_rx_s2 [QB+1];
	logic [CB:0]       dv_ry_s2 [QB+1];
	logic [QB-1:0]     dv_qx_s2 [QB+1];
	logic [QB-1:0]     dv_qy_s2 [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s2[0] <= 1'b0;
		end else if (en) begin
			dv_v_s2[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_f_s2[0]  <= func;
			dv_in_s2[0] <= inside_c;
			dv_x_s2[0]  <= pos_x;
			dv_y_s2[0]  <= pos_y;
			dv_ch_s2[0] <= {chan2, chan1, chan0};
			dv_lx_s2[0] <= lx_c;
			dv_ly_s2[0] <= ly_c;
			dv_rx_s2[0] <= (CB+1)'(nx_c >> QB);
			dv_ry_s2[0] <= (CB+1)'(ny_c >> QB);
			dv_qx_s2[0] <= nx_c[QB-1:0];
			dv_qy_s2[0] <= ny_c[QB-1:0];
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		logic [CB+1:0] tx, ty;
		logic          gx, gy;

		always_comb begin
			tx = {dv_rx_s2[k], dv_qx_s2[k][QB-1]};
			ty = {dv_ry_s2[k], dv_qy_s2[k][QB-1]};
			gx = tx >= {1'b0, dv_lx_s2[k]};
			gy = ty >= {1'b0, dv_ly_s2[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s2[k+1] <= 1'b0;
			end else if (en) begin
				dv_v_s2[k+1] <= dv_v_s2[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_f_s2[k+1]  <= dv_f_s2[k];
				dv_in_s2[k+1] <= dv_in_s2[k];
				dv_x_s2[k+1]  <= dv_x_s2[k];
				dv_y_s2[k+1]  <= dv_y_s2[k];
				dv_ch_s2[k+1] <= dv_ch_s2[k];
				dv_lx_s2[k+1] <= dv_lx_s2[k];
				dv_ly_s2[k+1] <= dv_ly_s2[k];
				dv_rx_s2[k+1] <= gx ? (CB+1)'(tx - {1'b0, dv_lx_s2[k]}) : tx[CB:0];
				dv_ry_s2[k+1] <= gy ? (CB+1)'(ty - {1'b0, dv_ly_s2[k]}) : ty[CB:0];
				dv_qx_s2[k+1] <= {dv_qx_s2[k][QB-2:0], gx};
				dv_qy_s2[k+1] <= {dv_qy_s2[k][QB-2:0], gy};
			end
		end
	end

	// ---------------- neighbour positions with edge clamp
	logic [PW-1:0] ix_c, iy_c, x0_c, y0_c, x1_c, y1_c;

	always_comb begin
		ix_c = PW'(dv_qx_s2[QB][QB-1:F]) + PW'(src_left_q);
		iy_c = PW'(dv_qy_s2[QB][QB-1:F]) + PW'(src_top_q);
		x0_c = (ix_c > XLAST) ? XLAST : ix_c;
		y0_c = (iy_c > YLAST) ? YLAST : iy_c;
		x1_c = (x0_c + PW'(1) > XLAST) ? XLAST : x0_c + PW'(1);
		y1_c = (y0_c + PW'(1) > YLAST) ? YLAST : y0_c + PW'(1);
	end

	logic            v_s3, f_s3, in_s3, wok_s3;
	logic [3*PB-1:0] ch_s3;
	logic [XB-1:0]   x0_s3, x1_s3, wx_s3;
	logic [YB-1:0]   y0_s3, y1_s3, wy_s3;
	logic [F-1:0]    fx_s3, fy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= dv_v_s2[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s3   <= dv_f_s2[QB];
			in_s3  <= dv_in_s2[QB];
			ch_s3  <= dv_ch_s2[QB];
			x0_s3  <= x0_c[XB-1:0];
			x1_s3  <= x1_c[XB-1:0];
			y0_s3  <= y0_c[YB-1:0];
			y1_s3  <= y1_c[YB-1:0];
			fx_s3  <= dv_qx_s2[QB][F-1:0];
			fy_s3  <= dv_qy_s2[QB][F-1:0];
			wx_s3  <= dv_x_s2[QB][XB-1:0];
			wy_s3  <= dv_y_s2[QB][YB-1:0];
			wok_s3 <= (PW'(dv_x_s2[QB]) <= XLAST) && (PW'(dv_y_s2[QB]) <= YLAST) &&
				(dv_x_s2[QB] == CB'(PW'(dv_x_s2[QB]))) &&
				(dv_y_s2[QB] == CB'(PW'(dv_y_s2[QB])));
		end
	end

	// ---------------- four parity banks
	logic [SW-1:0] rd_s4 [4];
	logic          we_c;
	logic [AW-1:0] wa_c;

	always_comb begin
		we_c = en && v_s3 && (f_s3 == bcpc_pkg::FUNC_LOAD) && wok_s3;
		wa_c = AW'(32'(wy_s3 >> 1) * HW + 32'(wx_s3 >> 1));
	end

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [SW-1:0] mem [BD];
		logic [XB-1:0] col;
		logic [YB-1:0] row;
		logic [AW-1:0] ra;

		always_comb begin
			col = (x0_s3[0] == b[0]) ? x0_s3 : x1_s3;
			row = (y0_s3[0] == b[1]) ? y0_s3 : y1_s3;
			ra  = AW'(32'(row >> 1) * HW + 32'(col >> 1));
		end

		always_ff @(posedge clk) begin
			if (we_c && wx_s3[0] == b[0] && wy_s3[0] == b[1]) begin
				mem[wa_c] <= ch_s3[SW-1:0];
			end
			if (en) begin
				rd_s4[b] <= mem[ra];
			end
		end
	end

	logic            v_s4, f_s4, in_s4;
	logic [3*PB-1:0] ch_s4;
	logic [1:0]      sa_s4, sb_s4, sc_s4, sd_s4;
	logic [WW-1:0]   wa_s4, wb_s4, wc_s4, wd_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s4  <= f_s3;
			in_s4 <= in_s3;
			ch_s4 <= ch_s3;
			sa_s4 <= {y0_s3[0], x0_s3[0]};
			sb_s4 <= {y0_s3[0], x1_s3[0]};
			sc_s4 <= {y1_s3[0], x0_s3[0]};
			sd_s4 <= {y1_s3[0], x1_s3[0]};
			wa_s4 <= WW'((ONE - {1'b0, fx_s3}) * (ONE - {1'b0, fy_s3}));
			wb_s4 <= WW'({1'b0, fx_s3} * (ONE - {1'b0, fy_s3}));
			wc_s4 <= WW'({1'b0, fy_s3} * (ONE - {1'b0, fx_s3}));
			wd_s4 <= WW'({1'b0, fx_s3} * {1'b0, fy_s3});
		end
	end

	// ---------------- weight products, then sum
	logic            v_s5, f_s5, in_s5;
	logic [3*PB-1:0] ch_s5;
	logic [MW-1:0]   pa_s5 [SCH];
	logic [MW-1:0]   pb_s5 [SCH];
	logic [MW-1:0]   pc_s5 [SCH];
	logic [MW-1:0]   pd_s5 [SCH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s5  <= f_s4;
			in_s5 <= in_s4;
			ch_s5 <= ch_s4;
		end
	end

	for (genvar c = 0; c < SCH; c++) begin : g_mul
		always_ff @(posedge clk) begin
			if (en) begin
				pa_s5[c] <= MW'(rd_s4[sa_s4][c*PB +: PB] * wa_s4);
				pb_s5[c] <= MW'(rd_s4[sb_s4][c*PB +: PB] * wb_s4);
				pc_s5[c] <= MW'(rd_s4[sc_s4][c*PB +: PB] * wc_s4);
				pd_s5[c] <= MW'(rd_s4[sd_s4][c*PB +: PB] * wd_s4);
			end
		end
	end

	logic [3*PB-1:0] pix_c;

	for (genvar c = 0; c < bcpc_pkg::IO_CH; c++) begin : g_sum
		if (c < SCH) begin : g_on
			logic [UW-1:0] sum;
			logic [UW-1:0] sh;
			always_comb begin
				sum = UW'(pa_s5[c]) + UW'(pb_s5[c]) + UW'(pc_s5[c]) + UW'(pd_s5[c]);
				sh  = sum >> (2 * F);
				if (!in_s5) begin
					pix_c[c*PB +: PB] = ch_s5[c*PB +: PB];
				end else if (sh > UW'(255)) begin
					pix_c[c*PB +: PB] = PB'(255);
				end else begin
					pix_c[c*PB +: PB] = sh[PB-1:0];
				end
			end
		end else begin : g_off
			assign pix_c[c*PB +: PB] = '0;
		end
	end

	// ---------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s5 && (f_s5 == bcpc_pkg::FUNC_PROCESS);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix0     <= pix_c[0 +: PB];
			pix1     <= pix_c[PB +: PB];
			pix2     <= pix_c[2*PB +: PB];
			in_patch <= in_s5;
		end
	end

	// ---------------- checks
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v_s2[QB] && dv_in_s2[QB] && dv_f_s2[QB] |-> dv_rx_s2[QB] < dv_lx_s2[QB]
			&& dv_ry_s2[QB] < dv_ly_s2[QB])
		else $error("position divider remainder not below divisor");

	a_wsum: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (2*F+3)'(wa_s4) + (2*F+3)'(wb_s4) + (2*F+3)'(wc_s4) + (2*F+3)'(wd_s4)
			== (2*F+3)'(1) << (2 * F))
		else $error("bilinear weights do not sum to one");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s5 && (f_s5 == bcpc_pkg::FUNC_LOAD) |=> !out_valid)
		else $error("load beat produced a result");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result dropped without being taken");

endmodule
`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bilinear crop/patch compositor. It loads the
// parts of the source store that samples read and runs a short directed
// table, then random phases under several crop and patch settings. Every
// result is checked against a known table pixel or an in-bench bilinear model.
// ----------------------------------------------------------------------------
module tb;

	localparam int SW = bcpc_pkg::STORE_WIDTH;
	localparam int SH = bcpc_pkg::STORE_HEIGHT;
	localparam int F  = bcpc_pkg::FRACTION_BITS;

	typedef struct {
		logic        fn;
		logic [11:0] x;
		logic [11:0] y;
		logic [7:0]  c0, c1, c2;
	} beat_t;

	typedef struct {
		logic [7:0] p0, p1, p2;
		logic       inp;
	} pixel_t;

	typedef struct {
		beat_t  b;
		logic   known;
		pixel_t px;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [bcpc_pkg::CFG_IDX_W-1:0] cfg_index = bcpc_pkg::REG_SRC_LEFT;
	logic [11:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic func = bcpc_pkg::FUNC_LOAD;
	logic [11:0] pos_x = '0, pos_y = '0;
	logic [7:0] chan0 = '0, chan1 = '0, chan2 = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] pix0, pix1, pix2;
	logic in_patch;

	bilinear_crop_patch_compositor_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .func(func),
		.pos_x(pos_x), .pos_y(pos_y), .chan0(chan0), .chan1(chan1), .chan2(chan2),
		.out_valid(out_valid), .out_ready(out_ready),
		.pix0(pix0), .pix1(pix1), .pix2(pix2), .in_patch(in_patch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#50_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	logic [23:0] src_image [0:SW*SH-1];
	bit          written [0:SW*SH-1];
	logic [6:0]  crop_l = 0, crop_t = 0, crop_r = 127, crop_b = 127;
	logic [11:0] patch_l = 0, patch_t = 0, patch_r = 127, patch_b = 127;
	pixel_t      pending_pixels [$];
	int          errors = 0;
	logic        no_gaps = 1'b0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic in_rect(beat_t b);
		return b.x >= patch_l && b.x <= patch_r && b.y >= patch_t && b.y <= patch_b;
	endfunction

	// neighbour columns and rows plus fractions for a beat inside the patch
	function automatic void sample_pos(beat_t b, output int x0, output int x1,
			output int y0, output int y1, output longint unsigned fx,
			output longint unsigned fy);
		longint unsigned sw, sh, px, py, ix, iy, fmask;
		fmask = (64'd1 << F) - 64'd1;
		sw = (crop_r >= crop_l) ? longint'(crop_r) - longint'(crop_l) + 1 : 1;
		sh = (crop_b >= crop_t) ? longint'(crop_b) - longint'(crop_t) + 1 : 1;
		px = (((longint'(b.x) - longint'(patch_l)) * sw) << F) /
			(longint'(patch_r) - longint'(patch_l) + 1);
		py = (((longint'(b.y) - longint'(patch_t)) * sh) << F) /
			(longint'(patch_b) - longint'(patch_t) + 1);
		fx = px & fmask;
		fy = py & fmask;
		ix = (px >> F) + longint'(crop_l);
		iy = (py >> F) + longint'(crop_t);
		x0 = (ix > SW - 1) ? SW - 1 : int'(ix);
		y0 = (iy > SH - 1) ? SH - 1 : int'(iy);
		x1 = (x0 == SW - 1) ? x0 : x0 + 1;
		y1 = (y0 == SH - 1) ? y0 : y0 + 1;
	endfunction

	// a sample may only touch pixels that were loaded
	function automatic logic sample_ok(beat_t b);
		int x0, x1, y0, y1;
		longint unsigned fx, fy;
		if (b.fn == bcpc_pkg::FUNC_LOAD || !in_rect(b)) return 1'b1;
		sample_pos(b, x0, x1, y0, y1, fx, fy);
		return written[y0*SW + x0] && written[y0*SW + x1] &&
			written[y1*SW + x0] && written[y1*SW + x1];
	endfunction

	// bilinear sample or background pass-through for one destination beat
	function automatic pixel_t composite_pixel(beat_t b);
		pixel_t r;
		longint unsigned fx, fy, one, wa, wb, wc, wd, sum;
		int x0, x1, y0, y1;
		logic [23:0] na, nb, nc, nd;
		one = 64'd1 << F;
		if (in_rect(b)) begin
			sample_pos(b, x0, x1, y0, y1, fx, fy);
			wa = (one - fx) * (one - fy);
			wb = fx * (one - fy);
			wc = fy * (one - fx);
			wd = fx * fy;
			na = src_image[y0*SW + x0];
			nb = src_image[y0*SW + x1];
			nc = src_image[y1*SW + x0];
			nd = src_image[y1*SW + x1];
			sum = na[7:0]*wa + nb[7:0]*wb + nc[7:0]*wc + nd[7:0]*wd;
			r.p0 = 8'(sum >> (2 * F));
			sum = na[15:8]*wa + nb[15:8]*wb + nc[15:8]*wc + nd[15:8]*wd;
			r.p1 = 8'(sum >> (2 * F));
			sum = na[23:16]*wa + nb[23:16]*wb + nc[23:16]*wc + nd[23:16]*wd;
			r.p2 = 8'(sum >> (2 * F));
			r.inp = 1'b1;
		end else begin
			r.p0 = b.c0;
			r.p1 = b.c1;
			r.p2 = b.c2;
			r.inp = 1'b0;
		end
		return r;
	endfunction

	task automatic write_reg(logic [bcpc_pkg::CFG_IDX_W-1:0] idx, logic [11:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			bcpc_pkg::REG_SRC_LEFT:   crop_l = val[6:0];
			bcpc_pkg::REG_SRC_TOP:    crop_t = val[6:0];
			bcpc_pkg::REG_SRC_RIGHT:  crop_r = val[6:0];
			bcpc_pkg::REG_SRC_BOTTOM: crop_b = val[6:0];
			bcpc_pkg::REG_DST_LEFT:   patch_l = val;
			bcpc_pkg::REG_DST_TOP:    patch_t = val;
			bcpc_pkg::REG_DST_RIGHT:  patch_r = val;
			default:                  patch_b = val;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// random upper bits on crop writes check that only seven bits are kept
	task automatic set_geometry(int sl, int st, int sr, int sb, int dl, int dt, int dr,
			int db);
		write_reg(bcpc_pkg::REG_SRC_LEFT, 12'(sl) | 12'($urandom_range(0, 31) << 7));
		write_reg(bcpc_pkg::REG_SRC_TOP, 12'(st) | 12'($urandom_range(0, 31) << 7));
		write_reg(bcpc_pkg::REG_SRC_RIGHT, 12'(sr) | 12'($urandom_range(0, 31) << 7));
		write_reg(bcpc_pkg::REG_SRC_BOTTOM, 12'(sb) | 12'($urandom_range(0, 31) << 7));
		write_reg(bcpc_pkg::REG_DST_LEFT, 12'(dl));
		write_reg(bcpc_pkg::REG_DST_TOP, 12'(dt));
		write_reg(bcpc_pkg::REG_DST_RIGHT, 12'(dr));
		write_reg(bcpc_pkg::REG_DST_BOTTOM, 12'(db));
	endtask

	// valid is already low or held from the previous beat on entry
	task automatic send_beat(beat_t b, logic known, pixel_t ref_px);
		int gap;
		pixel_t p;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		func <= b.fn;
		pos_x <= b.x;
		pos_y <= b.y;
		chan0 <= b.c0;
		chan1 <= b.c1;
		chan2 <= b.c2;
		do @(posedge clk); while (!in_ready);
		if (b.fn == bcpc_pkg::FUNC_LOAD) begin
			if (b.x < SW && b.y < SH) begin
				src_image[b.y*SW + b.x] = {b.c2, b.c1, b.c0};
				written[b.y*SW + b.x] = 1'b1;
			end
		end else begin
			p = composite_pixel(b);
			if (known && (p.p0 != ref_px.p0 || p.p1 != ref_px.p1 ||
					p.p2 != ref_px.p2 || p.inp != ref_px.inp) && errors < 10)
				$display("table row disagrees with model at x=%0d y=%0d", b.x, b.y);
			pending_pixels.push_back(known ? ref_px : p);
		end
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_block(int x_lo, int x_hi, int y_lo, int y_hi);
		beat_t b;
		pixel_t none;
		none = '{default: '0};
		for (int yy = y_lo; yy <= y_hi; yy++)
			for (int xx = x_lo; xx <= x_hi; xx++) begin
				b = '{bcpc_pkg::FUNC_LOAD, 12'(xx), 12'(yy),
					8'($urandom), 8'($urandom), 8'($urandom)};
				send_beat(b, 1'b0, none);
			end
	endtask

	// redraw until every sampled neighbour is loaded, else fall back to a load
	function automatic beat_t random_beat();
		beat_t b;
		int r;
		for (int t = 0; t < 200; t++) begin
			r = $urandom_range(0, 99);
			b.c0 = 8'($urandom);
			b.c1 = 8'($urandom);
			b.c2 = 8'($urandom);
			b.x = 12'($urandom);
			b.y = 12'($urandom);
			if (r < 15) begin
				b.fn = bcpc_pkg::FUNC_LOAD;
				if (r < 11) begin
					b.x = 12'($urandom_range(0, SW - 1));
					b.y = 12'($urandom_range(0, SH - 1));
				end
			end else begin
				b.fn = bcpc_pkg::FUNC_PROCESS;
				if (r < 80 && patch_r >= patch_l && patch_b >= patch_t) begin
					b.x = 12'(patch_l + $urandom_range(0, patch_r - patch_l));
					b.y = 12'(patch_t + $urandom_range(0, patch_b - patch_t));
				end
			end
			if (sample_ok(b)) return b;
		end
		b.fn = bcpc_pkg::FUNC_LOAD;
		b.x = 12'($urandom_range(0, SW - 1));
		b.y = 12'($urandom_range(0, SH - 1));
		return b;
	endfunction

	task automatic random_phase(int n);
		pixel_t none;
		none = '{default: '0};
		repeat (n) send_beat(random_beat(), 1'b0, none);
		drain();
	endtask

	// hold out_ready low once for a long stretch so the pipeline backs up
	int   hold_left = 0;
	logic hold_req = 1'b0;
	logic long_done = 1'b0;
	int   ready_gap = 0;
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!long_done && hold_req) begin
			long_done = 1'b1;
			hold_left = 400;
			out_ready <= 1'b0;
		end else if (ready_gap > 0) begin
			ready_gap--;
			out_ready <= 1'b0;
		end else begin
			ready_gap = no_gaps ? 0 : pick_gap();
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		pixel_t want;
		if (out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected beat pix=%h %h %h in_patch=%b",
						pix0, pix1, pix2, in_patch);
			end else begin
				want = pending_pixels.pop_front();
				if (pix0 !== want.p0 || pix1 !== want.p1 || pix2 !== want.p2 ||
						in_patch !== want.inp) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: want %h %h %h/%b got %h %h %h/%b",
							want.p0, want.p1, want.p2, want.inp,
							pix0, pix1, pix2, in_patch);
				end
			end
		end
	end

	row_t table_rows [$];

	task automatic add_row(logic fn, int x, int y, int c0, int c1, int c2, logic known,
			int e0, int e1, int e2, logic einp);
		row_t r;
		r.b = '{fn, 12'(x), 12'(y), 8'(c0), 8'(c1), 8'(c2)};
		r.known = known;
		r.px = '{8'(e0), 8'(e1), 8'(e2), einp};
		table_rows.push_back(r);
	endtask

	initial begin
		beat_t b;
		pixel_t none;
		none = '{default: '0};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// load every region that the table and the phases below sample
		no_gaps = 1'b1;
		load_block(0, 2, 0, 1);
		load_block(8, 19, 18, 25);
		load_block(120, 127, 125, 127);
		load_block(90, 91, 80, 81);
		no_gaps = 1'b0;

		// directed table at reset geometry
		add_row(bcpc_pkg::FUNC_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(bcpc_pkg::FUNC_LOAD, 127, 127, 255, 255, 255, 0, 0, 0, 0, 0);
		add_row(bcpc_pkg::FUNC_LOAD, 1, 0, 255, 0, 255, 0, 0, 0, 0, 0);
		add_row(bcpc_pkg::FUNC_LOAD, 128, 5, 9, 9, 9, 0, 0, 0, 0, 0);
		add_row(bcpc_pkg::FUNC_LOAD, 5, 128, 9, 9, 9, 0, 0, 0, 0, 0);
		add_row(bcpc_pkg::FUNC_LOAD, 4095, 4095, 9, 9, 9, 0, 0, 0, 0, 0);
		add_row(bcpc_pkg::FUNC_PROCESS, 0, 0, 1, 2, 3, 1, 0, 0, 0, 1);
		add_row(bcpc_pkg::FUNC_PROCESS, 127, 127, 1, 2, 3, 1, 255, 255, 255, 1);
		add_row(bcpc_pkg::FUNC_PROCESS, 1, 0, 0, 0, 0, 1, 255, 0, 255, 1);
		add_row(bcpc_pkg::FUNC_PROCESS, 4095, 4095, 255, 255, 255, 1, 255, 255, 255, 0);
		add_row(bcpc_pkg::FUNC_PROCESS, 128, 0, 0, 0, 0, 1, 0, 0, 0, 0);
		add_row(bcpc_pkg::FUNC_PROCESS, 0, 128, 170, 85, 15, 1, 170, 85, 15, 0);
		add_row(bcpc_pkg::FUNC_PROCESS, 2048, 1024, 240, 7, 128, 1, 240, 7, 128, 0);
		add_row(bcpc_pkg::FUNC_PROCESS, 10, 20, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(bcpc_pkg::FUNC_PROCESS, 126, 127, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(bcpc_pkg::FUNC_PROCESS, 15, 22, 0, 0, 0, 0, 0, 0, 0, 0);
		foreach (table_rows[i])
			send_beat(table_rows[i].b, table_rows[i].known, table_rows[i].px);
		drain();

		random_phase(30);
		// upscale a small crop into a big patch, with the receiver stalled first
		set_geometry(10, 20, 17, 23, 100, 200, 163, 231);
		hold_req = 1'b1;
		random_phase(30);
		// crop at the store corner: right and bottom neighbours clamp
		set_geometry(120, 125, 127, 127, 0, 0, 40, 30);
		random_phase(30);
		// inverted crop: single column and row
		set_geometry(90, 80, 3, 2, 5, 5, 20, 20);
		random_phase(20);
		// inverted patch: all background
		set_geometry(0, 0, 127, 127, 300, 300, 299, 400);
		random_phase(15);
		// stretch a small crop over the full destination range
		set_geometry(10, 20, 17, 23, 0, 0, 4095, 4095);
		random_phase(30);
		// single-pixel patch at the far corner
		set_geometry(127, 127, 127, 127, 4095, 4095, 4095, 4095);
		random_phase(15);
		b = '{bcpc_pkg::FUNC_PROCESS, 12'd4095, 12'd4095, 8'd0, 8'd0, 8'd0};
		send_beat(b, 1'b0, none);
		drain();
		// downscale the loaded block into a small patch, back to back
		no_gaps = 1'b1;
		set_geometry(8, 18, 19, 25, 1000, 2000, 1005, 2002);
		random_phase(30);
		no_gaps = 1'b0;
		set_geometry(0, 0, 127, 127, 0, 0, 127, 127);
		random_phase(30);

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
